// ===== rtl/iibs_pkg.sv =====
// ----------------------------------------------------------------------------
// iibs_pkg
// shared types and defaults for the integral image box sum block
// ----------------------------------------------------------------------------
package iibs_pkg;

  localparam int unsigned DEF_MAX_COLS = 64;
  localparam int unsigned DEF_MAX_ROWS = 64;

  localparam int unsigned VAL_W  = 20;  // integral value and box sum
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned BOX_W  = 6;
  localparam int unsigned DIM_W  = 7;   // active_cols / active_rows registers
  localparam int unsigned IDX_W  = 1;   // config register index

  // config register indexes
  localparam logic [IDX_W-1:0] REG_ACTIVE_COLS = 1'b0;
  localparam logic [IDX_W-1:0] REG_ACTIVE_ROWS = 1'b1;

  // input item kinds
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // one input item
  typedef struct packed {
    logic             func;
    logic [PIX_W-1:0] pixel;
    logic             start_frame;
    logic [BOX_W-1:0] box_x;
    logic [BOX_W-1:0] box_y;
    logic [BOX_W-1:0] box_w;
    logic [BOX_W-1:0] box_h;
  } item_t;

  // one result item
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             out_of_range;
    logic             frame_complete;
  } res_t;

endpackage

// ===== rtl/iibs_mem.sv =====
// ----------------------------------------------------------------------------
// iibs_mem
// single-port synchronous ram, registered read
// ----------------------------------------------------------------------------
module iibs_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12,
  parameter int unsigned DW    = 20
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/iibs_ctrl.sv =====
// ----------------------------------------------------------------------------
// iibs_ctrl
// sequencer: raster load read-modify-write and four-corner query reads
// ----------------------------------------------------------------------------
module iibs_ctrl import iibs_pkg::*; #(
  parameter int unsigned MAX_COLS = DEF_MAX_COLS,
  parameter int unsigned MAX_ROWS = DEF_MAX_ROWS,
  parameter int unsigned AW       = $clog2(MAX_COLS * MAX_ROWS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [DIM_W-1:0] cfg_wdata_i,
  // item side
  input  logic             item_valid_i,
  output logic             item_ready_o,
  input  item_t            item_i,
  // result side
  output logic             res_valid_o,
  input  logic             res_take_i,
  output res_t             res_o,
  // memory port
  output logic             mem_en_o,
  output logic             mem_we_o,
  output logic [AW-1:0]    mem_addr_o,
  output logic [VAL_W-1:0] mem_wdata_o,
  input  logic [VAL_W-1:0] mem_rdata_i
);

  localparam int unsigned CW   = $clog2(MAX_COLS);
  localparam int unsigned RW   = $clog2(MAX_ROWS);
  localparam int unsigned CDW  = ($clog2(MAX_COLS + 1) > DIM_W) ? $clog2(MAX_COLS + 1) : DIM_W;
  localparam int unsigned RDW  = ($clog2(MAX_ROWS + 1) > DIM_W) ? $clog2(MAX_ROWS + 1) : DIM_W;
  localparam int unsigned SUMW = BOX_W + 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LD_RD, ST_LD_WR,
    ST_Q_RD0, ST_Q_RD1, ST_Q_RD2, ST_Q_RD3, ST_Q_LAST,
    ST_RES
  } state_e;

  state_e           state_q;
  logic [DIM_W-1:0] active_cols_q, active_rows_q;
  logic             frame_valid_q;
  logic [CW-1:0]    col_q;
  logic [RW-1:0]    row_q;
  logic [VAL_W-1:0] rsum_q;
  logic [PIX_W-1:0] pixel_q;
  logic [CW-1:0]    qx_q, qxr_q;
  logic [RW-1:0]    qy_q, qyb_q;
  logic [VAL_W-1:0] acc_q;
  res_t             res_q;

  logic [CDW-1:0]   cols_eff;
  logic [RDW-1:0]   rows_eff;
  logic [SUMW-1:0]  xr_sum, yb_sum;
  logic             q_refuse;
  logic [VAL_W-1:0] rsum_new, load_val;
  logic             col_wrap, row_wrap;

  function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] r, input logic [CW-1:0] c);
    addr_of = AW'(AW'(r) * AW'(MAX_COLS) + AW'(c));
  endfunction

  // register values clamped to 1..max
  always_comb begin
    if (active_cols_q == '0) begin
      cols_eff = CDW'(1);
    end else if (CDW'(active_cols_q) > CDW'(MAX_COLS)) begin
      cols_eff = CDW'(MAX_COLS);
    end else begin
      cols_eff = CDW'(active_cols_q);
    end
    if (active_rows_q == '0) begin
      rows_eff = RDW'(1);
    end else if (RDW'(active_rows_q) > RDW'(MAX_ROWS)) begin
      rows_eff = RDW'(MAX_ROWS);
    end else begin
      rows_eff = RDW'(active_rows_q);
    end
  end

  assign xr_sum   = SUMW'(item_i.box_x) + SUMW'(item_i.box_w);
  assign yb_sum   = SUMW'(item_i.box_y) + SUMW'(item_i.box_h);
  assign q_refuse = !frame_valid_q || (CDW'(xr_sum) >= cols_eff) || (RDW'(yb_sum) >= rows_eff);

  assign rsum_new = ((col_q == '0) ? '0 : rsum_q) + VAL_W'(pixel_q);
  assign load_val = rsum_new + ((row_q != '0) ? mem_rdata_i : '0);
  assign col_wrap = (CDW'(col_q) + CDW'(1)) >= cols_eff;
  assign row_wrap = (RDW'(row_q) + RDW'(1)) >= rows_eff;

  // memory access per state
  always_comb begin
    mem_en_o    = 1'b0;
    mem_we_o    = 1'b0;
    mem_addr_o  = addr_of(row_q, col_q);
    mem_wdata_o = load_val;
    case (state_q)
      ST_LD_RD: begin
        mem_en_o   = (row_q != '0);
        mem_addr_o = addr_of(row_q - RW'(1), col_q);
      end
      ST_LD_WR: begin
        mem_en_o = 1'b1;
        mem_we_o = 1'b1;
      end
      ST_Q_RD0: begin
        mem_en_o   = 1'b1;
        mem_addr_o = addr_of(qyb_q, qxr_q);
      end
      ST_Q_RD1: begin
        mem_en_o   = 1'b1;
        mem_addr_o = addr_of(qy_q, qx_q);
      end
      ST_Q_RD2: begin
        mem_en_o   = 1'b1;
        mem_addr_o = addr_of(qy_q, qxr_q);
      end
      ST_Q_RD3: begin
        mem_en_o   = 1'b1;
        mem_addr_o = addr_of(qyb_q, qx_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      active_cols_q <= DIM_W'(64);
      active_rows_q <= DIM_W'(64);
      frame_valid_q <= 1'b0;
      col_q         <= '0;
      row_q         <= '0;
      rsum_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        frame_valid_q <= 1'b0;
        case (cfg_idx_i)
          REG_ACTIVE_COLS: active_cols_q <= cfg_wdata_i;
          REG_ACTIVE_ROWS: active_rows_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          if (item_valid_i) begin
            if (item_i.func == FUNC_LOAD) begin
              pixel_q <= item_i.pixel;
              if (item_i.start_frame) begin
                col_q <= '0;
                row_q <= '0;
              end
              state_q <= ST_LD_RD;
            end else begin
              qx_q  <= CW'(item_i.box_x);
              qy_q  <= RW'(item_i.box_y);
              qxr_q <= CW'(xr_sum);
              qyb_q <= RW'(yb_sum);
              if (q_refuse) begin
                res_q   <= '{value: '0, out_of_range: 1'b1, frame_complete: 1'b0};
                state_q <= ST_RES;
              end else begin
                state_q <= ST_Q_RD0;
              end
            end
          end
        end
        ST_LD_RD: state_q <= ST_LD_WR;
        ST_LD_WR: begin
          rsum_q <= rsum_new;
          res_q  <= '{value: load_val, out_of_range: 1'b0,
                      frame_complete: col_wrap && row_wrap};
          if (col_wrap) begin
            col_q <= '0;
            if (row_wrap) begin
              row_q         <= '0;
              frame_valid_q <= 1'b1;
            end else begin
              row_q <= row_q + RW'(1);
            end
          end else begin
            col_q <= col_q + CW'(1);
          end
          state_q <= ST_RES;
        end
        ST_Q_RD0: state_q <= ST_Q_RD1;
        ST_Q_RD1: begin
          acc_q   <= mem_rdata_i;
          state_q <= ST_Q_RD2;
        end
        ST_Q_RD2: begin
          acc_q   <= acc_q + mem_rdata_i;
          state_q <= ST_Q_RD3;
        end
        ST_Q_RD3: begin
          acc_q   <= acc_q - mem_rdata_i;
          state_q <= ST_Q_LAST;
        end
        ST_Q_LAST: begin
          res_q   <= '{value: acc_q - mem_rdata_i, out_of_range: 1'b0, frame_complete: 1'b0};
          state_q <= ST_RES;
        end
        ST_RES: begin
          if (res_take_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign item_ready_o = (state_q == ST_IDLE);
  assign res_valid_o  = (state_q == ST_RES);
  assign res_o        = res_q;

endmodule

// ===== rtl/integral_image_box_sum.sv =====
// ----------------------------------------------------------------------------
// integral_image_box_sum
// summed-area table builder with four-corner box-sum queries
// ----------------------------------------------------------------------------
// usage
// - slave stream carries one item per transfer: tuser[0] selects load (0) or
//   query (1), tuser[1] restarts the raster on a load
// - a load writes the next raster pixel's inclusive integral value and
//   returns it; tlast on the result marks the last pixel of a frame
// - a query returns the box sum of rows y+1..y+h, columns x+1..x+w; tuser on
//   the result flags a refused query (no full frame yet, or a corner outside
//   the image), with value 0
// - config port writes active_cols (index 0) and active_rows (index 1); any
//   write invalidates the loaded frame
// - sequence: a load passes through a table read, a table write and the result
//   state before it reaches the output register, and the next item is taken
//   after that; a query makes its four reads on the single-port table ram, and
//   a refused query goes straight to the result state
// - one item is in flight at a time; the output register holds a result so
//   the next item is taken while the master side waits, and the sequencer
//   only stalls when a second result is ready with the register still full
// - reset clears raster position, row sum and frame-valid and sets both
//   sizes to 64; the table ram itself is not cleared
// ----------------------------------------------------------------------------
module integral_image_box_sum import iibs_pkg::*; #(
  parameter int unsigned MAX_COLS = DEF_MAX_COLS,
  parameter int unsigned MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration write port
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [DIM_W-1:0] cfg_wdata_i,
  // input stream
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [31:0]      s_axis_tdata_i,  // pixel, box_x, box_y, box_w, box_h
  input  logic [1:0]       s_axis_tuser_i,  // func, start_frame
  // result stream
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [23:0]      m_axis_tdata_o,  // value, zero fill
  output logic             m_axis_tuser_o,  // out_of_range
  output logic             m_axis_tlast_o   // frame_complete
);

  localparam int unsigned DEPTH = MAX_COLS * MAX_ROWS;
  localparam int unsigned AW    = $clog2(DEPTH);

  item_t            item;
  res_t             res;
  logic             res_valid, res_take;
  logic             mem_en, mem_we;
  logic [AW-1:0]    mem_addr;
  logic [VAL_W-1:0] mem_wdata, mem_rdata;

  // output register
  logic             out_valid_q;
  res_t             out_q;

  // unpack the input transfer
  assign item.func        = s_axis_tuser_i[0];
  assign item.start_frame = s_axis_tuser_i[1];
  assign item.pixel       = s_axis_tdata_i[7:0];
  assign item.box_x       = s_axis_tdata_i[13:8];
  assign item.box_y       = s_axis_tdata_i[19:14];
  assign item.box_w       = s_axis_tdata_i[25:20];
  assign item.box_h       = s_axis_tdata_i[31:26];

  iibs_ctrl #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .AW       (AW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (s_axis_tvalid_i),
    .item_ready_o (s_axis_tready_o),
    .item_i       (item),
    .res_valid_o  (res_valid),
    .res_take_i   (res_take),
    .res_o        (res),
    .mem_en_o     (mem_en),
    .mem_we_o     (mem_we),
    .mem_addr_o   (mem_addr),
    .mem_wdata_o  (mem_wdata),
    .mem_rdata_i  (mem_rdata)
  );

  // integral table, one entry per pixel position
  iibs_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (VAL_W)
  ) u_mem (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // result moves into the output register when it is empty or draining
  assign res_take = res_valid && (!out_valid_q || m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (res_take) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, out_q.value};
  assign m_axis_tuser_o  = out_q.out_of_range;
  assign m_axis_tlast_o  = out_q.frame_complete;

endmodule

// ===== test/integral_image_box_sum_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integral_image_box_sum_tb
// self-checking bench for the summed-area table builder and box-sum queries
// ----------------------------------------------------------------------------
// a generator fills a queue of load and query items phase by phase and keeps
// a planning copy of the table so that no query or load ever reads a table
// entry that was never written. a clocked driver sends the items, a second
// copy of the table predicts each result at the input transfer, and a
// clocked monitor compares every result transfer with the oldest prediction.
// both sides idle at random; one long receiver hold fills the block up.
// ----------------------------------------------------------------------------
module integral_image_box_sum_tb;
  import iibs_pkg::*;

  localparam int          PLAN        = 0;     // table copy used by the generator
  localparam int          LIVE        = 1;     // table copy used for checking
  localparam int unsigned SAT_DEPTH   = DEF_MAX_COLS * DEF_MAX_ROWS;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned TAIL_CYCLES = 12;
  localparam int unsigned RAND_ITEMS  = 350;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [IDX_W-1:0] cfg_idx   = '0;
  logic [DIM_W-1:0] cfg_wdata = '0;
  logic             s_tvalid  = 1'b0;
  logic             s_tready;
  logic [31:0]      s_tdata;
  logic [1:0]       s_tuser;
  logic             m_tvalid;
  logic             m_tready  = 1'b0;
  logic [23:0]      m_tdata;
  logic             m_tuser;
  logic             m_tlast;

  // table model, two copies indexed by PLAN / LIVE
  logic [VAL_W-1:0] sat_mem   [2][SAT_DEPTH];
  bit               sat_wr    [2][SAT_DEPTH];
  logic [VAL_W-1:0] row_sum   [2] = '{'0, '0};
  int unsigned      ras_col   [2] = '{0, 0};
  int unsigned      ras_row   [2] = '{0, 0};
  bit               frame_ok  [2] = '{1'b0, 1'b0};
  logic [DIM_W-1:0] size_cols [2] = '{7'd64, 7'd64};
  logic [DIM_W-1:0] size_rows [2] = '{7'd64, 7'd64};

  item_t       ops_to_send[$];
  res_t        expected_sums[$];
  item_t       tx_item       = '0;
  int unsigned tx_wait       = 0;
  int unsigned rx_wait       = 0;
  int unsigned hold_cnt      = 0;
  bit          hold_req      = 1'b0;
  bit          hold_done     = 1'b0;
  int unsigned send_gap_max  = 15;
  int unsigned recv_gap_max  = 15;
  int unsigned mismatches    = 0;
  int unsigned idle_cycles   = 0;
  int unsigned n_sent        = 0;
  bit          last_done     = 1'b0;

  always #10 clk = ~clk;

  integral_image_box_sum u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // pixel, box_x, box_y, box_w, box_h
    .s_axis_tuser_i  (s_tuser),   // func, start_frame
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),   // value, zero fill
    .m_axis_tuser_o  (m_tuser),   // out_of_range
    .m_axis_tlast_o  (m_tlast)    // frame_complete
  );

  assign s_tdata = {tx_item.box_h, tx_item.box_w, tx_item.box_y, tx_item.box_x,
                    tx_item.pixel};
  assign s_tuser = {tx_item.start_frame, tx_item.func};

  // ---------------------------------------------------------------------------
  // table model
  // ---------------------------------------------------------------------------

  // register value as the block uses it: 0 acts as 1, above max acts as max
  function automatic int unsigned dim_eff(logic [DIM_W-1:0] v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // any size write drops the loaded frame
  function automatic void size_write(int m, logic [IDX_W-1:0] idx, logic [DIM_W-1:0] v);
    if (idx == REG_ACTIVE_COLS) size_cols[m] = v;
    else size_rows[m] = v;
    frame_ok[m] = 1'b0;
  endfunction

  // applies one item to table copy m and returns its result
  function automatic res_t sat_apply(int m, item_t it);
    res_t        r;
    int unsigned cols, rows, c, ro, x, y, xr, yb;
    logic [VAL_W-1:0] v;
    cols = dim_eff(size_cols[m], DEF_MAX_COLS);
    rows = dim_eff(size_rows[m], DEF_MAX_ROWS);
    r = '0;
    if (it.func == FUNC_LOAD) begin
      if (it.start_frame) begin
        ras_col[m] = 0;
        ras_row[m] = 0;
      end
      c  = ras_col[m];
      ro = ras_row[m];
      if (c == 0) row_sum[m] = '0;
      row_sum[m] = row_sum[m] + VAL_W'(it.pixel);
      v = row_sum[m];
      if (ro > 0) v = v + sat_mem[m][(ro - 1) * DEF_MAX_COLS + c];
      sat_mem[m][ro * DEF_MAX_COLS + c] = v;
      sat_wr[m][ro * DEF_MAX_COLS + c]  = 1'b1;
      // wrap on or past the last active column / row (matters after a shrink)
      if (c + 1 >= cols) begin
        ras_col[m] = 0;
        if (ro + 1 >= rows) begin
          ras_row[m]       = 0;
          frame_ok[m]      = 1'b1;
          r.frame_complete = 1'b1;
        end else begin
          ras_row[m] = ro + 1;
        end
      end else begin
        ras_col[m] = c + 1;
      end
      r.value = v;
    end else begin
      x  = it.box_x;
      y  = it.box_y;
      xr = x + it.box_w;
      yb = y + it.box_h;
      if (!frame_ok[m] || xr >= cols || yb >= rows) begin
        r.out_of_range = 1'b1;
      end else begin
        r.value = sat_mem[m][yb * DEF_MAX_COLS + xr] + sat_mem[m][y * DEF_MAX_COLS + x]
                - sat_mem[m][y * DEF_MAX_COLS + xr] - sat_mem[m][yb * DEF_MAX_COLS + x];
      end
    end
    return r;
  endfunction

  // true when every table entry the item reads has been written
  function automatic bit reads_ok(int m, item_t it);
    int unsigned cols, rows, x, y, xr, yb;
    if (it.func == FUNC_LOAD)
      return it.start_frame || ras_row[m] == 0 ||
             sat_wr[m][(ras_row[m] - 1) * DEF_MAX_COLS + ras_col[m]];
    cols = dim_eff(size_cols[m], DEF_MAX_COLS);
    rows = dim_eff(size_rows[m], DEF_MAX_ROWS);
    x  = it.box_x;
    y  = it.box_y;
    xr = x + it.box_w;
    yb = y + it.box_h;
    if (!frame_ok[m] || xr >= cols || yb >= rows) return 1'b1;
    return sat_wr[m][yb * DEF_MAX_COLS + xr] && sat_wr[m][y * DEF_MAX_COLS + x] &&
           sat_wr[m][y * DEF_MAX_COLS + xr] && sat_wr[m][yb * DEF_MAX_COLS + x];
  endfunction

  // ---------------------------------------------------------------------------
  // driver: one item per transfer, random gap drawn after each transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin : tx_proc
    int unsigned g;
    if (!rst_n) begin
      s_tvalid <= 1'b0;
      tx_wait  <= 0;
    end else if (s_tvalid && s_tready) begin
      expected_sums.push_back(sat_apply(LIVE, tx_item));
      g = $urandom_range(0, send_gap_max);
      if (g == 0 && ops_to_send.size() != 0) begin
        // back to back: valid stays high
        tx_item  <= ops_to_send.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
        tx_wait  <= (g == 0) ? 0 : g - 1;
      end
    end else if (!s_tvalid) begin
      if (tx_wait != 0) begin
        tx_wait <= tx_wait - 1;
      end else if (ops_to_send.size() != 0) begin
        tx_item  <= ops_to_send.pop_front();
        s_tvalid <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each result transfer, then draws its own stall
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin : rx_proc
    int unsigned g;
    res_t        want;
    if (!rst_n) begin
      m_tready  <= 1'b0;
      rx_wait   <= 0;
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_sums.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: value %0d oor %0b last %0b",
                     m_tdata[VAL_W-1:0], m_tuser, m_tlast);
        end else begin
          want = expected_sums.pop_front();
          if (m_tdata[VAL_W-1:0] !== want.value || m_tuser !== want.out_of_range ||
              m_tlast !== want.frame_complete) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: expected value %0d oor %0b last %0b, ",
                        "got value %0d oor %0b last %0b"},
                       want.value, want.out_of_range, want.frame_complete,
                       m_tdata[VAL_W-1:0], m_tuser, m_tlast);
          end
        end
      end
      if (hold_req && !hold_done) begin
        // long hold-off so the block fills up and stalls its input
        hold_done <= 1'b1;
        hold_cnt  <= HOLD_CYCLES;
        m_tready  <= 1'b0;
      end else if (hold_cnt != 0) begin
        hold_cnt <= hold_cnt - 1;
      end else if (m_tvalid && m_tready) begin
        g = $urandom_range(0, recv_gap_max);
        if (g == 0) begin
          m_tready <= 1'b1;
        end else begin
          m_tready <= 1'b0;
          rx_wait  <= g - 1;
        end
      end else if (!m_tready) begin
        if (rx_wait != 0) rx_wait <= rx_wait - 1;
        else m_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // every field random, so the unused fields of each kind toggle too
  function automatic item_t rand_item();
    item_t it;
    it.func        = 1'($urandom_range(0, 1));
    it.pixel       = 8'($urandom_range(0, 255));
    it.start_frame = 1'($urandom_range(0, 1));
    it.box_x       = 6'($urandom_range(0, 63));
    it.box_y       = 6'($urandom_range(0, 63));
    it.box_w       = 6'($urandom_range(0, 63));
    it.box_h       = 6'($urandom_range(0, 63));
    return it;
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel(bit all_max);
    if (all_max) return 8'hff;
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // loads that would read a never-written row above get a restart; such
  // queries are dropped
  task automatic send(item_t it);
    res_t r;
    if (!reads_ok(PLAN, it)) begin
      if (it.func == FUNC_QUERY) return;
      it.start_frame = 1'b1;
    end
    r = sat_apply(PLAN, it);
    last_done = r.frame_complete;
    ops_to_send.push_back(it);
    n_sent++;
  endtask

  // n loads, or until the frame completes when n is 0
  task automatic load_pixels(int unsigned n, bit all_max, bit restart);
    item_t       it;
    int unsigned i;
    i = 0;
    do begin
      it             = rand_item();
      it.func        = FUNC_LOAD;
      it.pixel       = pick_pixel(all_max);
      it.start_frame = restart && i == 0;
      send(it);
      i++;
    end while (n == 0 ? !last_done : i < n);
  endtask

  task automatic ask(int unsigned x, int unsigned y, int unsigned w, int unsigned h,
                     bit restart_bit);
    item_t it;
    it             = rand_item();
    it.func        = FUNC_QUERY;
    it.start_frame = restart_bit;
    it.box_x       = 6'(x);
    it.box_y       = 6'(y);
    it.box_w       = 6'(w);
    it.box_h       = 6'(h);
    send(it);
  endtask

  task automatic ask_boxes(int unsigned n);
    int unsigned cols, rows, x, y, w, h;
    item_t       it;
    cols = dim_eff(size_cols[PLAN], DEF_MAX_COLS);
    rows = dim_eff(size_rows[PLAN], DEF_MAX_ROWS);
    repeat (n) begin
      x = $urandom_range(0, cols - 1);
      y = $urandom_range(0, rows - 1);
      w = $urandom_range(0, cols - 1 - x);
      h = $urandom_range(0, rows - 1 - y);
      case ($urandom_range(0, 9))
        0, 1: begin
          // raw fields, nearly always outside the image
          it      = rand_item();
          it.func = FUNC_QUERY;
          send(it);
        end
        2: begin
          // one corner just past the right or bottom edge
          if ($urandom_range(0, 1)) w = (cols - x > 63) ? 63 : cols - x;
          else h = (rows - y > 63) ? 63 : rows - y;
          ask(x, y, w, h, 1'($urandom_range(0, 1)));
        end
        3:       ask(0, 0, cols - 1, rows - 1, 1'($urandom_range(0, 1)));
        default: ask(x, y, w, h, 1'($urandom_range(0, 1)));
      endcase
    end
  endtask

  // config port, only used while the block is idle
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    size_write(PLAN, idx, val);
    size_write(LIVE, idx, val);
  endtask

  // sender pause until every result has come back
  task automatic drain();
    while (ops_to_send.size() != 0 || s_tvalid || expected_sums.size() != 0)
      @(posedge clk);
  endtask

  initial begin : stim
    int unsigned base, phase, cols, rows;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part ---
    // query before any frame is refused
    ask(0, 0, 0, 0, 1'b0);
    drain();
    // zero sizes act as a 1x1 image; the single load completes the frame
    write_reg(REG_ACTIVE_COLS, 7'd0);
    write_reg(REG_ACTIVE_ROWS, 7'd0);
    load_pixels(0, 1'b1, 1'b0);
    ask(0, 0, 0, 0, 1'b0);
    ask(0, 0, 1, 0, 1'b0);
    ask(0, 0, 0, 1, 1'b0);
    drain();
    // 3x2 frame of full-scale pixels, exact edge corners, restart bit on a query
    write_reg(REG_ACTIVE_COLS, 7'd3);
    write_reg(REG_ACTIVE_ROWS, 7'd2);
    load_pixels(0, 1'b1, 1'b1);
    ask(0, 0, 2, 1, 1'b0);
    ask(1, 0, 1, 1, 1'b1);
    ask(0, 0, 3, 0, 1'b0);
    ask(0, 0, 2, 2, 1'b0);
    ask(63, 63, 63, 63, 1'b0);
    drain();
    // shrink the image while the raster sits past the new right edge
    write_reg(REG_ACTIVE_COLS, 7'd8);
    write_reg(REG_ACTIVE_ROWS, 7'd8);
    load_pixels(12, 1'b0, 1'b1);
    drain();
    write_reg(REG_ACTIVE_COLS, 7'd3);
    write_reg(REG_ACTIVE_ROWS, 7'd2);
    load_pixels(0, 1'b0, 1'b0);
    ask(0, 0, 2, 1, 1'b0);
    drain();

    // --- widest image (width above max clamps), full-scale pixels, no idling ---
    send_gap_max = 0;
    recv_gap_max = 0;
    write_reg(REG_ACTIVE_COLS, 7'd127);
    write_reg(REG_ACTIVE_ROWS, 7'd3);
    load_pixels(0, 1'b1, 1'b1);
    ask(0, 0, 63, 2, 1'b0);
    ask_boxes(10);
    drain();

    // --- random phases ---
    base  = n_sent;
    phase = 0;
    while (n_sent - base < RAND_ITEMS) begin
      drain();
      send_gap_max = $urandom_range(0, 1) ? 15 : 0;
      recv_gap_max = $urandom_range(0, 1) ? 15 : 0;
      if (phase == 2) begin
        send_gap_max = 0;
        hold_req <= 1'b1;
      end
      case ($urandom_range(0, 9))
        0: begin
          cols = 0;
          rows = $urandom_range(0, 8);
        end
        1: begin
          cols = $urandom_range(64, 127);
          rows = $urandom_range(1, 3);
        end
        2: begin
          cols = $urandom_range(1, 3);
          rows = $urandom_range(64, 127);
        end
        default: begin
          cols = $urandom_range(1, 8);
          rows = $urandom_range(1, 8);
        end
      endcase
      case ($urandom_range(0, 9))
        0: write_reg(REG_ACTIVE_COLS, 7'(cols));
        1: write_reg(REG_ACTIVE_ROWS, 7'(rows));
        2: ;  // keep sizes and the loaded frame
        default: begin
          write_reg(REG_ACTIVE_COLS, 7'(cols));
          write_reg(REG_ACTIVE_ROWS, 7'(rows));
        end
      endcase
      // queries right after a size write are refused
      if ($urandom_range(0, 3) == 0) ask_boxes(2);
      // mostly a clean frame from the origin, sometimes carry on from
      // wherever the raster stands
      load_pixels(0, 1'b0, $urandom_range(0, 5) != 0);
      if ($urandom_range(0, 4) == 0) drain();
      ask_boxes($urandom_range(5, 25));
      // restarted frame: the table becomes a mix of old and new rows
      if ($urandom_range(0, 3) == 0) begin
        load_pixels($urandom_range(1, 6), 1'b0, 1'b1);
        ask_boxes(5);
      end
      phase++;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_sums.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
